// ----- rtl/pufc_pkg.sv -----
// Shared types and constants for the parity claim checker.
// No dependencies; imported by pufc_table and parity_union_find_checker.
package pufc_pkg;

	localparam int SEQ_LENGTH_DEF = 1023;
	localparam int LE_W           = 10;
	localparam int COUNT_W        = 16;

	typedef struct packed {
		logic [LE_W-1:0] left_end;
		logic [LE_W-1:0] right_end;
		logic            claim_odd;
	} in_t;

	typedef struct packed {
		logic               conflict;
		logic [COUNT_W-1:0] accepted_count;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_COMP,
		ST_LINK,
		ST_DONE
	} state_t;

	// Which node the current find works on.
	typedef enum logic [2:0] {
		PH_A,
		PH_C,
		PH_D,
		PH_AP,
		PH_C2
	} phase_t;

endpackage

// ----- rtl/pufc_table.sv -----
// Parent table memory: one write port, one read port with registered data,
// and the clearing pass that loads every entry with its own index after reset.
// Depends on pufc_pkg.
module pufc_table
	import pufc_pkg::*;
#(
	parameter int DEPTH = 2 * (SEQ_LENGTH_DEF + 1),
	parameter int NW    = $clog2(2 * (SEQ_LENGTH_DEF + 1))
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] rd_addr,
	output logic [NW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [NW-1:0] wr_addr,
	input  logic [NW-1:0] wr_data,
	output logic          ready
);

	logic [NW-1:0] mem [DEPTH];
	logic          init_q;
	logic [NW-1:0] idx_q;
	logic          we;
	logic [NW-1:0] wa;
	logic [NW-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			idx_q  <= '0;
		end else if (init_q) begin
			if (idx_q == NW'(DEPTH - 1)) begin
				init_q <= 1'b0;
			end
			idx_q <= idx_q + NW'(1);
		end
	end

	assign we = init_q | wr_en;
	assign wa = init_q ? idx_q : wr_addr;
	assign wd = init_q ? idx_q : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data <= mem[rd_addr];
	end

	assign ready = ~init_q;

endmodule

// ----- rtl/parity_union_find_checker.sv -----
// Parity claim checker. Each beat on the input claims that a segment of the
// sequence holds an odd or even number of ones; each claim yields one result
// beat with the sticky conflict flag and the saturating count of claims taken
// before the first conflict. After reset the parent table is cleared by a
// pass over every entry, during which no claim is accepted. A consistent
// claim runs five finds through the table memory, one memory read per cycle:
// each find issues a read of its start node, follows the path node by node
// up to and including the root, and then lets path compression rewrite the
// nodes on that path; a find that starts at a root needs no compression.
// Besides the finds, a claim passes through the accept step, up to two link
// writes and the result step. A claim that adds new relations makes both link
// writes, one that repeats relations already known skips both link writes,
// and a contradicting claim stops after its second find. A claim that arrives
// after a conflict, or with an endpoint outside 1..SEQ_LENGTH, goes straight
// to the result. The result cycle stretches while the previous result beat waits.
module parity_union_find_checker
	import pufc_pkg::*;
#(
	parameter int SEQ_LENGTH = SEQ_LENGTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int HALF  = SEQ_LENGTH + 1;
	localparam int NODES = 2 * HALF;
	localparam int NW    = $clog2(NODES);
	localparam logic [NW-1:0] HALF_N = NW'(HALF);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	logic [NW-1:0] rd_addr, rd_data, wr_addr, wr_data;
	logic          wr_en, tbl_ready;

	logic [NW-1:0] a_q, c_q, d_q, ap_q;
	logic [NW-1:0] walk_q, start_q, root_q, ra_q;
	logic          fail_q, conflict_q;
	logic [COUNT_W-1:0] count_q;
	logic          out_valid_q;
	out_t          out_q;

	logic          accept, bad, fdone, finish;
	logic [NW-1:0] froot, node_sel, in_a, in_b;
	logic          new_conflict;

	pufc_table #(
		.DEPTH(NODES),
		.NW   (NW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.ready  (tbl_ready)
	);

	assign in_ready = (state_q == ST_IDLE) && tbl_ready;
	assign accept   = in_valid && in_ready;
	assign bad = (in_data.left_end == '0) || (in_data.right_end == '0) ||
		(32'(in_data.left_end) > 32'(SEQ_LENGTH)) ||
		(32'(in_data.right_end) > 32'(SEQ_LENGTH));
	assign in_a = NW'(in_data.left_end - LE_W'(1));
	assign in_b = NW'(in_data.right_end);
	assign finish = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign new_conflict = conflict_q | fail_q;

	always_comb begin
		case (phase_q)
			PH_A:    node_sel = a_q;
			PH_C:    node_sel = c_q;
			PH_D:    node_sel = d_q;
			PH_AP:   node_sel = ap_q;
			PH_C2:   node_sel = c_q;
			default: node_sel = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_A;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		rd_addr = walk_q;
		wr_en   = 1'b0;
		wr_addr = walk_q;
		wr_data = root_q;
		fdone   = 1'b0;
		froot   = walk_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					phase_d = PH_A;
					state_d = (conflict_q || bad) ? ST_DONE : ST_START;
				end
			end
			ST_START: begin
				rd_addr = node_sel;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (rd_data == walk_q) begin
					if (start_q == walk_q) begin
						fdone = 1'b1;
						froot = walk_q;
					end else begin
						rd_addr = start_q;
						state_d = ST_COMP;
					end
				end else begin
					rd_addr = rd_data;
				end
			end
			ST_COMP: begin
				// Point the node at its root, then follow its old parent.
				wr_en = 1'b1;
				if (rd_data == root_q) begin
					fdone = 1'b1;
					froot = root_q;
				end else begin
					rd_addr = rd_data;
				end
			end
			ST_LINK: begin
				wr_en   = 1'b1;
				wr_addr = ra_q;
				wr_data = root_q;
				if (phase_q == PH_D) begin
					phase_d = PH_AP;
					state_d = ST_START;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (fdone) begin
			case (phase_q)
				PH_A: begin
					phase_d = PH_C;
					state_d = ST_START;
				end
				PH_C: begin
					if (froot == ra_q) begin
						state_d = ST_DONE;
					end else begin
						phase_d = PH_D;
						state_d = ST_START;
					end
				end
				PH_D: begin
					if (froot != ra_q) begin
						state_d = ST_LINK;
					end else begin
						phase_d = PH_AP;
						state_d = ST_START;
					end
				end
				PH_AP: begin
					phase_d = PH_C2;
					state_d = ST_START;
				end
				PH_C2: state_d = (froot != ra_q) ? ST_LINK : ST_DONE;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// Claim nodes and find pointers.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q  <= in_a;
			ap_q <= in_a + HALF_N;
			// c is the node that must not share a root with a; d joins a.
			c_q  <= in_data.claim_odd ? in_b : in_b + HALF_N;
			d_q  <= in_data.claim_odd ? in_b + HALF_N : in_b;
		end
		case (state_q)
			ST_START: begin
				walk_q  <= node_sel;
				start_q <= node_sel;
			end
			ST_WALK: begin
				if (rd_data == walk_q) begin
					root_q <= walk_q;
					walk_q <= start_q;
				end else begin
					walk_q <= rd_data;
				end
			end
			ST_COMP: begin
				walk_q <= rd_data;
			end
			default: begin
			end
		endcase
		// froot holds the root when a find completes; root_q does so only after compression.
		if (fdone) begin
			if (phase_q == PH_A || phase_q == PH_AP) begin
				ra_q <= froot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_q      <= 1'b0;
			conflict_q  <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fail_q <= bad;
			end else if (fdone && phase_q == PH_C && froot == ra_q) begin
				fail_q <= 1'b1;
			end
			if (finish) begin
				conflict_q  <= new_conflict;
				out_valid_q <= 1'b1;
				if (!new_conflict && count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.conflict <= new_conflict;
			out_q.accepted_count <= (!new_conflict && count_q != COUNT_MAX) ?
				count_q + COUNT_W'(1) : count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
